FILE: sv/lobm_pkg.sv
// Shared types, codes and constants of the limit order book matcher.
package lobm_pkg;

	localparam int MaxOrdersDefault = 32;
	localparam int MaxTrades        = 32;
	localparam int TradeCntW        = 6;

	typedef logic [31:0] word_t;

	// Order type codes.
	localparam logic [1:0] OT_GTC    = 2'd0;
	localparam logic [1:0] OT_FAK    = 2'd1;
	localparam logic [1:0] OT_FOK    = 2'd2;
	localparam logic [1:0] OT_MARKET = 2'd3;

	localparam logic SIDE_BUY = 1'b0;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes of the final record.
	localparam logic [2:0] ST_RESTED    = 3'd0;
	localparam logic [2:0] ST_FILLED    = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_DUP       = 3'd3;
	localparam logic [2:0] ST_NO_LIQ    = 3'd4;
	localparam logic [2:0] ST_NO_CROSS  = 3'd5;
	localparam logic [2:0] ST_NOT_FILL  = 3'd6;
	localparam logic [2:0] ST_FULL      = 3'd7;

	// Fields of a resting order that never change after it is stored.
	typedef struct packed {
		word_t id;
		logic  side;
		word_t price;
		word_t arrival;
	} info_t;

	// Write and valid-bit controls of the order table.
	typedef struct packed {
		logic info_we;
		logic rem_we;
		logic vset;
		logic vclr;
	} tbl_ctl_t;

	// Summary of one pass over the order table.
	typedef struct packed {
		logic  dup;
		logic  opp_any;
		word_t opp_worst;
		word_t opp_best;
		logic  free_any;
		logic  bid_any;
		word_t bid_price;
		word_t bid_rem;
		word_t bid_id;
		logic  ask_any;
		word_t ask_price;
		word_t ask_rem;
		word_t ask_id;
	} scan_res_t;

endpackage

FILE: sv/lobm_if.sv
// Valid/ready channel interfaces for incoming orders and result records.
interface lobm_order_if;
	logic        valid;
	logic        ready;
	logic [31:0] order_id;
	logic        side;
	logic [1:0]  order_type;
	logic [31:0] limit_price;
	logic [31:0] order_qty;

	modport source (output valid, order_id, side, order_type, limit_price, order_qty,
		input ready);
	modport sink (input valid, order_id, side, order_type, limit_price, order_qty,
		output ready);
endinterface

interface lobm_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] buyer_id;
	logic [31:0] buyer_price;
	logic [31:0] seller_id;
	logic [31:0] seller_price;
	logic [31:0] traded_qty;
	logic        buyer_done;
	logic        seller_done;
	logic [2:0]  status;
	logic        is_last;

	modport source (output valid, kind, buyer_id, buyer_price, seller_id, seller_price,
		traded_qty, buyer_done, seller_done, status, is_last, input ready);
	modport sink (input valid, kind, buyer_id, buyer_price, seller_id, seller_price,
		traded_qty, buyer_done, seller_done, status, is_last, output ready);
endinterface

FILE: sv/lobm_table.sv
// Order table: field memories with registered read and per-slot valid bits.
module lobm_table #(
	parameter int MAX_ORDERS = lobm_pkg::MaxOrdersDefault,
	parameter int IW = $clog2(MAX_ORDERS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IW-1:0]       rd_addr,
	output lobm_pkg::info_t     rd_info,
	output lobm_pkg::word_t     rd_rem,
	output logic                rd_valid,
	input  lobm_pkg::tbl_ctl_t  ctl,
	input  logic [IW-1:0]       wr_addr,
	input  lobm_pkg::info_t     wr_info,
	input  lobm_pkg::word_t     wr_rem,
	input  logic [IW-1:0]       probe_addr,
	output logic                probe_valid
);
	import lobm_pkg::*;

	info_t info_mem [MAX_ORDERS];
	word_t rem_mem  [MAX_ORDERS];
	logic [MAX_ORDERS-1:0] valid_q;
	info_t info_q;
	word_t rem_q;
	logic  rvalid_q;

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (ctl.info_we) begin
			info_mem[wr_addr] <= wr_info;
		end
		if (ctl.rem_we) begin
			rem_mem[wr_addr] <= wr_rem;
		end
		info_q <= info_mem[rd_addr];
		rem_q  <= rem_mem[rd_addr];
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (ctl.vset) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (ctl.vclr) begin
				valid_q[wr_addr] <= 1'b0;
			end
			rvalid_q <= valid_q[rd_addr];
		end
	end

	assign rd_info     = info_q;
	assign rd_rem      = rem_q;
	assign rd_valid    = rvalid_q;
	assign probe_valid = valid_q[probe_addr];
endmodule

FILE: sv/lobm_scan.sv
// Table scan unit: walks all slots one per cycle and accumulates the book summary.
module lobm_scan #(
	parameter int MAX_ORDERS = lobm_pkg::MaxOrdersDefault,
	parameter int IW = $clog2(MAX_ORDERS),
	parameter int SW = 32 + $clog2(MAX_ORDERS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic [IW-1:0]       rd_addr,
	input  logic                ent_valid,
	input  lobm_pkg::info_t     ent_info,
	input  lobm_pkg::word_t     ent_rem,
	input  lobm_pkg::word_t     q_id,
	input  logic                q_side,
	input  lobm_pkg::word_t     q_price,
	input  lobm_pkg::word_t     now,
	output logic                done,
	output lobm_pkg::scan_res_t res,
	output logic [SW-1:0]       opp_sum,
	output logic [IW-1:0]       free_idx,
	output logic [IW-1:0]       bid_idx,
	output logic [IW-1:0]       ask_idx
);
	import lobm_pkg::*;

	localparam logic [IW-1:0] LastIdx = IW'(MAX_ORDERS - 1);

	logic          busy_q;
	logic [IW-1:0] cnt_q;
	logic          vld_s1;
	logic          last_s1;
	logic [IW-1:0] idx_s1;
	logic          done_q;

	scan_res_t     acc_q;
	logic [SW-1:0] sum_q;
	logic [IW-1:0] free_q, bid_q, ask_q;
	word_t         bid_age_q, ask_age_q;

	word_t age;
	logic  is_opp, crossing, live;
	logic  worse, better, bid_better, ask_better;

	// Address counter and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			idx_s1  <= '0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LastIdx) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			vld_s1  <= busy_q && !start;
			last_s1 <= cnt_q == LastIdx;
			idx_s1  <= cnt_q;
			done_q  <= vld_s1 && last_s1;
		end
	end

	// Per-entry compares.
	always_comb begin
		live   = vld_s1 && ent_valid;
		age    = now - ent_info.arrival;
		is_opp = ent_info.side != q_side;
		crossing = (q_side == SIDE_BUY) ? (q_price >= ent_info.price)
			: (q_price <= ent_info.price);
		worse  = (q_side == SIDE_BUY) ? (ent_info.price > acc_q.opp_worst)
			: (ent_info.price < acc_q.opp_worst);
		better = (q_side == SIDE_BUY) ? (ent_info.price < acc_q.opp_best)
			: (ent_info.price > acc_q.opp_best);
		bid_better = (ent_info.price > acc_q.bid_price)
			|| (ent_info.price == acc_q.bid_price && age > bid_age_q);
		ask_better = (ent_info.price < acc_q.ask_price)
			|| (ent_info.price == acc_q.ask_price && age > ask_age_q);
	end

	// Accumulators, cleared at the start of a pass.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q.dup      <= 1'b0;
			acc_q.opp_any  <= 1'b0;
			acc_q.free_any <= 1'b0;
			acc_q.bid_any  <= 1'b0;
			acc_q.ask_any  <= 1'b0;
			sum_q          <= '0;
		end else if (vld_s1) begin
			if (!ent_valid && !acc_q.free_any) begin
				acc_q.free_any <= 1'b1;
				free_q         <= idx_s1;
			end
			if (live) begin
				if (ent_info.id == q_id) begin
					acc_q.dup <= 1'b1;
				end
				if (is_opp) begin
					acc_q.opp_any <= 1'b1;
					if (!acc_q.opp_any || worse) begin
						acc_q.opp_worst <= ent_info.price;
					end
					if (!acc_q.opp_any || better) begin
						acc_q.opp_best <= ent_info.price;
					end
					if (crossing) begin
						sum_q <= sum_q + SW'(ent_rem);
					end
				end
				if (ent_info.side == SIDE_BUY) begin
					if (!acc_q.bid_any || bid_better) begin
						acc_q.bid_any   <= 1'b1;
						acc_q.bid_price <= ent_info.price;
						acc_q.bid_rem   <= ent_rem;
						acc_q.bid_id    <= ent_info.id;
						bid_age_q       <= age;
						bid_q           <= idx_s1;
					end
				end else begin
					if (!acc_q.ask_any || ask_better) begin
						acc_q.ask_any   <= 1'b1;
						acc_q.ask_price <= ent_info.price;
						acc_q.ask_rem   <= ent_rem;
						acc_q.ask_id    <= ent_info.id;
						ask_age_q       <= age;
						ask_q           <= idx_s1;
					end
				end
			end
		end
	end

	assign rd_addr  = cnt_q;
	assign done     = done_q;
	assign res      = acc_q;
	assign opp_sum  = sum_q;
	assign free_idx = free_q;
	assign bid_idx  = bid_q;
	assign ask_idx  = ask_q;
endmodule

FILE: sv/limit_order_book_matcher_unit.sv
// Top level of the limit order book matcher: sequencer, order table and scan unit.
// Each order is first checked in one full pass over the table and a decision step,
// stored, and then matched: every trade costs one pass, two table writes and the output
// transfer, which waits while the result channel stalls, and a last pass that finds no
// crossing ends with the status transfer. The table scan goes one slot per cycle through
// the scan unit. The order channel is ready only when the block is idle. At most 32
// trades are made per order; a crossing left over is matched when later orders arrive.
module limit_order_book_matcher_unit #(
	parameter int MAX_ORDERS = lobm_pkg::MaxOrdersDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	lobm_order_if.sink    order,
	lobm_result_if.source result
);
	import lobm_pkg::*;

	localparam int IW = $clog2(MAX_ORDERS);
	localparam int SW = 32 + $clog2(MAX_ORDERS + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PRE    = 9'b000000010,
		S_CHECK  = 9'b000000100,
		S_STORE  = 9'b000001000,
		S_BOOK   = 9'b000010000,
		S_MATCH  = 9'b000100000,
		S_WR_ASK = 9'b001000000,
		S_OUT_TR = 9'b010000000,
		S_OUT_ST = 9'b100000000
	} state_t;

	state_t state_q;

	word_t                id_q, price_q, qty_q, arrival_q;
	logic                 side_q;
	logic [1:0]           type_q;
	logic [IW-1:0]        me_q;
	logic [TradeCntW-1:0] trade_cnt_q;

	// Output register.
	logic  o_kind_q, o_bdone_q, o_sdone_q, o_last_q;
	word_t o_bid_q, o_bprice_q, o_sid_q, o_sprice_q, o_qty_q;
	logic [2:0] o_status_q;

	// Table and scan connections.
	logic [IW-1:0] rd_addr, wr_addr, free_idx, bid_idx, ask_idx;
	info_t         rd_info, wr_info;
	word_t         rd_rem, wr_rem;
	logic          rd_valid, probe_valid, scan_start, scan_done;
	tbl_ctl_t      ctl;
	scan_res_t     res;
	logic [SW-1:0] opp_sum;

	logic  in_xfer, out_xfer, opp_cross, book_cross, me_cancel;
	word_t trade_qty;

	lobm_table #(.MAX_ORDERS(MAX_ORDERS), .IW(IW)) u_table (
		.clk, .arst_n, .rd_addr, .rd_info, .rd_rem, .rd_valid, .ctl,
		.wr_addr, .wr_info, .wr_rem, .probe_addr(me_q), .probe_valid
	);

	lobm_scan #(.MAX_ORDERS(MAX_ORDERS), .IW(IW), .SW(SW)) u_scan (
		.clk, .arst_n, .start(scan_start), .rd_addr, .ent_valid(rd_valid),
		.ent_info(rd_info), .ent_rem(rd_rem), .q_id(id_q), .q_side(side_q),
		.q_price(price_q), .now(arrival_q), .done(scan_done), .res, .opp_sum,
		.free_idx, .bid_idx, .ask_idx
	);

	assign in_xfer  = order.valid && order.ready;
	assign out_xfer = result.valid && result.ready;

	// Decision terms from the latest scan.
	always_comb begin
		opp_cross  = res.opp_any && ((side_q == SIDE_BUY) ? (price_q >= res.opp_best)
			: (price_q <= res.opp_best));
		book_cross = res.bid_any && res.ask_any && (res.bid_price >= res.ask_price)
			&& (trade_cnt_q < TradeCntW'(MaxTrades));
		trade_qty  = (res.bid_rem < res.ask_rem) ? res.bid_rem : res.ask_rem;
		me_cancel  = probe_valid && (type_q == OT_FAK || type_q == OT_FOK);
	end

	// Table write controls.
	always_comb begin
		ctl        = '0;
		wr_addr    = me_q;
		wr_info    = '{id: id_q, side: side_q, price: price_q, arrival: arrival_q};
		wr_rem     = qty_q;
		scan_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				scan_start = in_xfer;
			end
			S_STORE: begin
				ctl.info_we = 1'b1;
				ctl.rem_we  = 1'b1;
				ctl.vset    = 1'b1;
				scan_start  = 1'b1;
			end
			S_MATCH: begin
				if (book_cross) begin
					wr_addr    = bid_idx;
					wr_rem     = res.bid_rem - trade_qty;
					ctl.rem_we = 1'b1;
					ctl.vclr   = res.bid_rem == trade_qty;
				end else begin
					ctl.vclr = me_cancel;
				end
			end
			S_WR_ASK: begin
				wr_addr    = ask_idx;
				wr_rem     = res.ask_rem - o_qty_q;
				ctl.rem_we = 1'b1;
				ctl.vclr   = o_sdone_q;
			end
			S_OUT_TR: begin
				scan_start = out_xfer;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			arrival_q   <= '0;
			trade_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					if (scan_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (res.dup || (type_q == OT_MARKET && !res.opp_any)
						|| (type_q == OT_FAK && !opp_cross)
						|| (type_q == OT_FOK && opp_sum < SW'(qty_q))
						|| qty_q == '0 || !res.free_any) begin
						state_q <= S_OUT_ST;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					arrival_q   <= arrival_q + 1'b1;
					trade_cnt_q <= '0;
					state_q     <= S_BOOK;
				end
				S_BOOK: begin
					if (scan_done) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= book_cross ? S_WR_ASK : S_OUT_ST;
				end
				S_WR_ASK: begin
					state_q <= S_OUT_TR;
				end
				S_OUT_TR: begin
					if (out_xfer) begin
						trade_cnt_q <= trade_cnt_q + 1'b1;
						state_q     <= S_BOOK;
					end
				end
				S_OUT_ST: begin
					if (out_xfer) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Order fields, result record and stored slot.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			id_q    <= order.order_id;
			side_q  <= order.side;
			type_q  <= order.order_type;
			price_q <= order.limit_price;
			qty_q   <= order.order_qty;
		end
		if (state_q == S_CHECK) begin
			me_q <= free_idx;
			if (type_q == OT_MARKET) begin
				price_q <= res.opp_worst;
				type_q  <= OT_GTC;
			end
			o_kind_q   <= KIND_STATUS;
			o_last_q   <= 1'b1;
			o_bid_q    <= '0;
			o_bprice_q <= '0;
			o_sid_q    <= '0;
			o_sprice_q <= '0;
			o_qty_q    <= '0;
			o_bdone_q  <= 1'b0;
			o_sdone_q  <= 1'b0;
			if (res.dup) begin
				o_status_q <= ST_DUP;
			end else if (type_q == OT_MARKET && !res.opp_any) begin
				o_status_q <= ST_NO_LIQ;
			end else if (type_q == OT_FAK && !opp_cross) begin
				o_status_q <= ST_NO_CROSS;
			end else if (type_q == OT_FOK && opp_sum < SW'(qty_q)) begin
				o_status_q <= ST_NOT_FILL;
			end else if (qty_q == '0) begin
				o_status_q <= ST_FILLED;
			end else begin
				o_status_q <= ST_FULL;
			end
		end
		if (state_q == S_MATCH) begin
			if (book_cross) begin
				o_kind_q   <= KIND_TRADE;
				o_last_q   <= 1'b0;
				o_status_q <= ST_RESTED;
				o_bid_q    <= res.bid_id;
				o_bprice_q <= res.bid_price;
				o_sid_q    <= res.ask_id;
				o_sprice_q <= res.ask_price;
				o_qty_q    <= trade_qty;
				o_bdone_q  <= res.bid_rem == trade_qty;
				o_sdone_q  <= res.ask_rem == trade_qty;
			end else begin
				o_kind_q   <= KIND_STATUS;
				o_last_q   <= 1'b1;
				o_bid_q    <= '0;
				o_bprice_q <= '0;
				o_sid_q    <= '0;
				o_sprice_q <= '0;
				o_qty_q    <= '0;
				o_bdone_q  <= 1'b0;
				o_sdone_q  <= 1'b0;
				if (me_cancel) begin
					o_status_q <= ST_CANCELLED;
				end else if (probe_valid) begin
					o_status_q <= ST_RESTED;
				end else begin
					o_status_q <= ST_FILLED;
				end
			end
		end
	end

	assign order.ready         = state_q == S_IDLE;
	assign result.valid        = state_q == S_OUT_TR || state_q == S_OUT_ST;
	assign result.kind         = o_kind_q;
	assign result.buyer_id     = o_bid_q;
	assign result.buyer_price  = o_bprice_q;
	assign result.seller_id    = o_sid_q;
	assign result.seller_price = o_sprice_q;
	assign result.traded_qty   = o_qty_q;
	assign result.buyer_done   = o_bdone_q;
	assign result.seller_done  = o_sdone_q;
	assign result.status       = o_status_q;
	assign result.is_last      = o_last_q;

	// The block takes no new order while a record is pending.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		order.ready |-> !result.valid)
		else $error("order accepted while a record is pending");

	// The final record is always a status record, and a trade record never is.
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.is_last == result.kind))
		else $error("record kind and last flag disagree");

	// The trade count per order stays within its limit.
	a_trade_limit: assert property (@(posedge clk) disable iff (!arst_n)
		trade_cnt_q <= TradeCntW'(MaxTrades))
		else $error("trade count over its limit");
endmodule
